// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, active during reset as well.
`define ASSERT_NEXT(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/pide_pkg.sv
package pide_pkg;

  localparam int unsigned BLOCK_DEPTH_DEF = 256;

  // One-hot expansion phases.
  typedef enum logic [11:0] {
    PH_OP         = 12'b000000000001,
    PH_ARG_COUNT  = 12'b000000000010,
    PH_ARG_CUSTOM = 12'b000000000100,
    PH_ARG_REPEAT = 12'b000000001000,
    PH_ZERO       = 12'b000000010000,
    PH_LIT        = 12'b000000100000,
    PH_BLOCK_IN   = 12'b000001000000,
    PH_REPLAY     = 12'b000010000000,
    PH_CUSTOM     = 12'b000100000000,
    PH_ZFILL      = 12'b001000000000,
    PH_DONE       = 12'b010000000000,
    PH_ERR        = 12'b100000000000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PACKED  = 2'd0,
    KIND_DRAIN   = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_BAD     = 2'd3
  } kind_t;

  localparam logic [2:0] OPC_ZERO   = 3'd0;
  localparam logic [2:0] OPC_COPY   = 3'd1;
  localparam logic [2:0] OPC_REPEAT = 3'd2;
  localparam logic [2:0] OPC_ILV_CP = 3'd3;
  localparam logic [2:0] OPC_ILV_Z  = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_OP   = 3'd1;
  localparam logic [2:0] ST_BAD_ARG  = 3'd2;
  localparam logic [2:0] ST_TOO_BIG  = 3'd3;
  localparam logic [2:0] ST_WRONG    = 3'd4;
  localparam logic [2:0] ST_MISMATCH = 3'd5;

  localparam logic [7:0] COUNT_MASK = 8'h1f;
  localparam logic [7:0] ARG_MASK   = 8'h7f;
  localparam logic [7:0] ARG_MORE   = 8'h80;

  localparam logic       CFG_PACKED_LEN   = 1'b0;
  localparam logic       CFG_UNPACKED_LEN = 1'b1;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic byte_valid;
    logic [7:0] out_byte;
    logic want_packed;
    logic [2:0] status;
    logic done_res;
  } result_t;

endpackage

// File: hw/rtl/pide_front.sv
module pide_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_cmd,
  input  logic [7:0]       in_packed_byte,
  output logic             q_valid,
  output pide_pkg::item_t  q_item,
  input  logic             q_take
);

  pide_pkg::item_t slot_r [2];
  logic [1:0] count_r, count_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_r, wr_nxt;
  logic       push, pop;
  pide_pkg::item_t cls;

  always_comb begin
    cls.data = in_packed_byte;
    case (in_cmd)
      pide_pkg::KIND_PACKED:  cls.kind = pide_pkg::KIND_PACKED;
      pide_pkg::KIND_DRAIN:   cls.kind = pide_pkg::KIND_DRAIN;
      pide_pkg::KIND_RESTART: cls.kind = pide_pkg::KIND_RESTART;
      default:                cls.kind = pide_pkg::KIND_BAD;
    endcase
  end

  assign in_stall  = (count_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign q_valid   = (count_r != 2'd0);
  assign q_item    = slot_r[rd_r];
  assign pop       = q_valid && q_take;
  assign count_nxt = 2'(count_r + {1'b0, push} - {1'b0, pop});
  assign rd_nxt    = pop ? !rd_r : rd_r;
  assign wr_nxt    = push ? !wr_r : wr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      rd_r    <= 1'b0;
      wr_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      rd_r    <= rd_nxt;
      wr_r    <= wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= cls;
    end
  end

endmodule

// File: hw/rtl/pide_back.sv
module pide_back #(
  parameter int unsigned BLOCK_DEPTH = pide_pkg::BLOCK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [31:0]       packed_length,
  input  logic [31:0]       unpacked_length,
  input  logic              q_valid,
  input  pide_pkg::item_t   q_item,
  output logic              q_take,
  output logic              res_valid,
  output pide_pkg::result_t res,
  input  logic              res_stall
);

  localparam int unsigned AW = $clog2(BLOCK_DEPTH);
  localparam int unsigned SW = AW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(BLOCK_DEPTH);

  typedef struct packed {
    pide_pkg::phase_t ph;
    logic [31:0]      rem;
    logic [31:0]      rep;
    logic [SW-1:0]    sidx;
  } seg_t;

  pide_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]    opc_r, opc_nxt;
  logic [31:0]   blk_r, blk_nxt;
  logic [31:0]   cus_r, cus_nxt;
  logic [31:0]   rep_r, rep_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic [2:0]    seen_r, seen_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [31:0]   pseen_r, pseen_nxt;
  logic [31:0]   prod_r, prod_nxt;
  logic [SW-1:0] sidx_r, sidx_nxt;
  logic [2:0]    err_r, err_nxt;
  logic          res_valid_r;
  pide_pkg::result_t res_r;

  logic [7:0]    mem [BLOCK_DEPTH];
  logic [7:0]    rd_data_r;
  logic          mem_we;
  logic [AW-1:0] waddr, raddr;

  logic          go, bv;
  logic [7:0]    ob;

  function automatic logic is_seg(pide_pkg::phase_t p);
    return p == pide_pkg::PH_ZERO || p == pide_pkg::PH_LIT || p == pide_pkg::PH_BLOCK_IN ||
           p == pide_pkg::PH_REPLAY || p == pide_pkg::PH_CUSTOM || p == pide_pkg::PH_ZFILL;
  endfunction

  function automatic logic wants(pide_pkg::phase_t p);
    return p == pide_pkg::PH_OP || p == pide_pkg::PH_ARG_COUNT ||
           p == pide_pkg::PH_ARG_CUSTOM || p == pide_pkg::PH_ARG_REPEAT ||
           p == pide_pkg::PH_LIT || p == pide_pkg::PH_BLOCK_IN || p == pide_pkg::PH_CUSTOM;
  endfunction

  function automatic seg_t enter(seg_t s, pide_pkg::phase_t p, logic [31:0] len);
    seg_t t;
    t      = s;
    t.ph   = p;
    t.rem  = len;
    t.sidx = '0;
    return t;
  endfunction

  // Skips finished or empty segments; at most three hops are ever needed.
  function automatic seg_t settle(seg_t s, logic [2:0] op, logic [31:0] blk,
                                  logic [31:0] cus);
    seg_t t;
    t = s;
    for (int i = 0; i < 4; i++) begin
      if (is_seg(t.ph) && t.rem == '0) begin
        case (t.ph)
          pide_pkg::PH_ZERO, pide_pkg::PH_LIT: begin
            t.ph = pide_pkg::PH_OP;
          end
          pide_pkg::PH_BLOCK_IN: begin
            if (t.rep == '0) begin
              t.ph = pide_pkg::PH_OP;
            end else if (op == pide_pkg::OPC_REPEAT) begin
              t = enter(t, (blk == '0) ? pide_pkg::PH_OP : pide_pkg::PH_REPLAY, blk);
            end else if (blk == '0 && cus == '0) begin
              t.ph = pide_pkg::PH_OP;
            end else begin
              t = enter(t, pide_pkg::PH_CUSTOM, cus);
            end
          end
          pide_pkg::PH_CUSTOM: begin
            if (op == pide_pkg::OPC_ILV_CP) begin
              t = enter(t, pide_pkg::PH_REPLAY, blk);
            end else begin
              t.rep = t.rep - 32'd1;
              t = enter(t, pide_pkg::PH_ZFILL, blk);
            end
          end
          pide_pkg::PH_REPLAY: begin
            t.rep = t.rep - 32'd1;
            if (t.rep == '0) begin
              t.ph = pide_pkg::PH_OP;
            end else if (op == pide_pkg::OPC_REPEAT) begin
              t = enter(t, pide_pkg::PH_REPLAY, blk);
            end else begin
              t = enter(t, pide_pkg::PH_CUSTOM, cus);
            end
          end
          default: begin
            if (t.rep == '0 || (blk == '0 && cus == '0)) begin
              t.ph = pide_pkg::PH_OP;
            end else begin
              t = enter(t, pide_pkg::PH_CUSTOM, cus);
            end
          end
        endcase
      end
    end
    return t;
  endfunction

  assign go     = q_valid && (!res_valid_r || !res_stall);
  assign q_take = go;

  always_comb begin
    seg_t s;
    logic [31:0] v;
    logic fin;
    phase_nxt = phase_r;
    opc_nxt   = opc_r;
    blk_nxt   = blk_r;
    cus_nxt   = cus_r;
    rep_nxt   = rep_r;
    acc_nxt   = acc_r;
    seen_nxt  = seen_r;
    rem_nxt   = rem_r;
    pseen_nxt = pseen_r;
    prod_nxt  = prod_r;
    sidx_nxt  = sidx_r;
    err_nxt   = err_r;
    bv        = 1'b0;
    ob        = 8'd0;
    mem_we    = 1'b0;
    v         = '0;
    fin       = 1'b0;
    s         = '{ph: phase_r, rem: rem_r, rep: rep_r, sidx: sidx_r};

    if (go) begin
      if (q_item.kind == pide_pkg::KIND_RESTART) begin
        phase_nxt = pide_pkg::PH_OP;
        opc_nxt = '0; blk_nxt = '0; cus_nxt = '0; rep_nxt = '0; acc_nxt = '0;
        seen_nxt = '0; rem_nxt = '0; pseen_nxt = '0; prod_nxt = '0;
        sidx_nxt = '0; err_nxt = pide_pkg::ST_OK;
      end else if (phase_r == pide_pkg::PH_ERR) begin
        phase_nxt = phase_r;
      end else if (q_item.kind == pide_pkg::KIND_BAD || phase_r == pide_pkg::PH_DONE ||
                   (q_item.kind == pide_pkg::KIND_PACKED) != wants(phase_r)) begin
        err_nxt = pide_pkg::ST_WRONG;
        phase_nxt = pide_pkg::PH_ERR;
      end else if (q_item.kind == pide_pkg::KIND_PACKED) begin
        if (pseen_r >= packed_length) begin
          err_nxt = pide_pkg::ST_MISMATCH;
          phase_nxt = pide_pkg::PH_ERR;
        end else if (phase_r == pide_pkg::PH_OP) begin
          pseen_nxt = pseen_r + 32'd1;
          opc_nxt = q_item.data[7:5];
          if (q_item.data[7:5] > pide_pkg::OPC_ILV_Z) begin
            err_nxt = pide_pkg::ST_BAD_OP;
            phase_nxt = pide_pkg::PH_ERR;
          end else begin
            cus_nxt = '0;
            rep_nxt = '0;
            blk_nxt = {24'd0, q_item.data & pide_pkg::COUNT_MASK};
            if (blk_nxt == '0) begin
              phase_nxt = pide_pkg::PH_ARG_COUNT;
            end else if (opc_nxt == pide_pkg::OPC_REPEAT) begin
              phase_nxt = pide_pkg::PH_ARG_REPEAT;
            end else if (opc_nxt == pide_pkg::OPC_ZERO || opc_nxt == pide_pkg::OPC_COPY) begin
              fin = 1'b1;
            end else begin
              phase_nxt = pide_pkg::PH_ARG_CUSTOM;
            end
          end
        end else if (phase_r == pide_pkg::PH_ARG_COUNT || phase_r == pide_pkg::PH_ARG_CUSTOM ||
                     phase_r == pide_pkg::PH_ARG_REPEAT) begin
          pseen_nxt = pseen_r + 32'd1;
          seen_nxt = 3'(seen_r + 3'd1);
          acc_nxt = {acc_r[24:0], q_item.data[6:0] & pide_pkg::ARG_MASK[6:0]};
          if ((q_item.data & pide_pkg::ARG_MORE) != 8'd0) begin
            if (seen_nxt >= 3'd5) begin
              err_nxt = pide_pkg::ST_BAD_ARG;
              phase_nxt = pide_pkg::PH_ERR;
            end
          end else begin
            v = acc_nxt;
            acc_nxt = '0;
            seen_nxt = '0;
            if (phase_r == pide_pkg::PH_ARG_COUNT) begin
              blk_nxt = v;
              if (opc_r == pide_pkg::OPC_ZERO || opc_r == pide_pkg::OPC_COPY) begin
                fin = 1'b1;
              end else if (opc_r == pide_pkg::OPC_REPEAT) begin
                phase_nxt = pide_pkg::PH_ARG_REPEAT;
              end else begin
                phase_nxt = pide_pkg::PH_ARG_CUSTOM;
              end
            end else if (phase_r == pide_pkg::PH_ARG_CUSTOM) begin
              cus_nxt = v;
              phase_nxt = pide_pkg::PH_ARG_REPEAT;
            end else begin
              rep_nxt = v;
              fin = 1'b1;
            end
          end
        end else if (prod_r >= unpacked_length) begin
          err_nxt = pide_pkg::ST_MISMATCH;
          phase_nxt = pide_pkg::PH_ERR;
        end else begin
          prod_nxt = prod_r + 32'd1;
          pseen_nxt = pseen_r + 32'd1;
          mem_we = (phase_r == pide_pkg::PH_BLOCK_IN) && (sidx_r < DEPTH_S);
          s.sidx = (sidx_r < DEPTH_S) ? SW'(sidx_r + 1'b1) : sidx_r;
          s.rem = rem_r - 32'd1;
          bv = 1'b1;
          ob = q_item.data;
          s = settle(s, opc_r, blk_r, cus_r);
          phase_nxt = s.ph; rem_nxt = s.rem; rep_nxt = s.rep; sidx_nxt = s.sidx;
        end
      end else if (prod_r >= unpacked_length) begin
        err_nxt = pide_pkg::ST_MISMATCH;
        phase_nxt = pide_pkg::PH_ERR;
      end else begin
        prod_nxt = prod_r + 32'd1;
        if (phase_r == pide_pkg::PH_REPLAY && sidx_r < DEPTH_S) begin
          ob = rd_data_r;
        end
        s.sidx = (sidx_r < DEPTH_S) ? SW'(sidx_r + 1'b1) : sidx_r;
        s.rem = rem_r - 32'd1;
        bv = 1'b1;
        s = settle(s, opc_r, blk_r, cus_r);
        phase_nxt = s.ph; rem_nxt = s.rem; rep_nxt = s.rep; sidx_nxt = s.sidx;
      end

      // The operation's arguments are complete: open the first segment.
      if (fin) begin
        s = '{ph: phase_r, rem: rem_r, rep: rep_nxt, sidx: sidx_r};
        if (opc_nxt == pide_pkg::OPC_ZERO) begin
          s = enter(s, pide_pkg::PH_ZERO, blk_nxt);
        end else if (opc_nxt == pide_pkg::OPC_COPY) begin
          s = enter(s, pide_pkg::PH_LIT, blk_nxt);
        end else if (opc_nxt == pide_pkg::OPC_ILV_Z) begin
          s = enter(s, pide_pkg::PH_ZFILL, blk_nxt);
        end else begin
          s = enter(s, pide_pkg::PH_BLOCK_IN, blk_nxt);
        end
        if (opc_nxt != pide_pkg::OPC_ZERO && opc_nxt != pide_pkg::OPC_COPY &&
            opc_nxt != pide_pkg::OPC_ILV_Z && blk_nxt > 32'(BLOCK_DEPTH)) begin
          err_nxt = pide_pkg::ST_TOO_BIG;
          phase_nxt = pide_pkg::PH_ERR;
        end else begin
          s = settle(s, opc_nxt, blk_nxt, cus_nxt);
          phase_nxt = s.ph; rem_nxt = s.rem; rep_nxt = s.rep; sidx_nxt = s.sidx;
        end
      end

      if (phase_nxt == pide_pkg::PH_OP && pseen_nxt >= packed_length) begin
        if (prod_nxt == unpacked_length) begin
          phase_nxt = pide_pkg::PH_DONE;
        end else begin
          err_nxt = pide_pkg::ST_MISMATCH;
          phase_nxt = pide_pkg::PH_ERR;
        end
      end
    end
  end

  assign waddr = sidx_r[AW-1:0];
  assign raddr = sidx_nxt[AW-1:0];

  // Block store: the byte at the next index is fetched ahead, with write bypass.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= q_item.data;
    end
    if (mem_we && waddr == raddr) begin
      rd_data_r <= q_item.data;
    end else begin
      rd_data_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= pide_pkg::PH_OP;
      opc_r       <= '0;
      blk_r       <= '0;
      cus_r       <= '0;
      rep_r       <= '0;
      acc_r       <= '0;
      seen_r      <= '0;
      rem_r       <= '0;
      pseen_r     <= '0;
      prod_r      <= '0;
      sidx_r      <= '0;
      err_r       <= pide_pkg::ST_OK;
      res_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      opc_r   <= opc_nxt;
      blk_r   <= blk_nxt;
      cus_r   <= cus_nxt;
      rep_r   <= rep_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      rem_r   <= rem_nxt;
      pseen_r <= pseen_nxt;
      prod_r  <= prod_nxt;
      sidx_r  <= sidx_nxt;
      err_r   <= err_nxt;
      if (go) begin
        res_valid_r <= 1'b1;
      end else if (!res_stall) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res_r.byte_valid  <= bv;
      res_r.out_byte    <= ob;
      res_r.want_packed <= wants(phase_nxt);
      res_r.status      <= err_nxt;
      res_r.done_res    <= (phase_nxt == pide_pkg::PH_DONE);
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// File: hw/rtl/pattern_init_data_expander.sv
// Path: an accepted item passes the queue slot, then the result register; the result
// is offered in the cycle after the engine takes the item from the queue.
// Throughput: one item per cycle while out_stall does not hold the result back; each
// item is one engine step; block bytes are prefetched from the single-read-port store.
// Reset (rst_n low, synchronous) clears the queue, the engine state and both length
// registers; the block store keeps its contents and needs no clearing pass.
`include "assert_macros.svh"

module pattern_init_data_expander #(
  parameter int unsigned BLOCK_DEPTH = pide_pkg::BLOCK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_packed_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_byte_valid,
  output logic [7:0]  out_byte,
  output logic        out_want_packed,
  output logic [2:0]  out_status,
  output logic        out_done_res,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] packed_len_r;
  logic [31:0] unpacked_len_r;
  logic        q_valid;
  logic        q_take;
  logic        res_bad;
  pide_pkg::item_t   q_item;
  pide_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packed_len_r   <= '0;
      unpacked_len_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == pide_pkg::CFG_PACKED_LEN) begin
        packed_len_r <= cfg_data;
      end else if (cfg_index == pide_pkg::CFG_UNPACKED_LEN) begin
        unpacked_len_r <= cfg_data;
      end
    end
  end

  pide_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_packed_byte (in_packed_byte),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_take         (q_take)
  );

  pide_back #(
    .BLOCK_DEPTH (BLOCK_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .packed_length   (packed_len_r),
    .unpacked_length (unpacked_len_r),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_take          (q_take),
    .res_valid       (out_valid),
    .res             (res),
    .res_stall       (out_stall)
  );

  assign out_byte_valid  = res.byte_valid;
  assign out_byte        = res.out_byte;
  assign out_want_packed = res.want_packed;
  assign out_status      = res.status;
  assign out_done_res    = res.done_res;

  assign res_bad = (out_status != pide_pkg::ST_OK);

  `ASSERT_IMPL(a_err_no_want, clk, rst_n, out_valid && res_bad, !out_want_packed)
  `ASSERT_IMPL(a_done_ok, clk, rst_n, out_valid && out_done_res, !res_bad && !out_want_packed)
  `ASSERT_NEXT(a_reset_empty, clk, !rst_n, !out_valid)

endmodule
